### hdl/websocket_frame_deframer_macros.svh
// ---------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shorthand for the concurrent assertions used by the port checker.
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Assertion that is switched off while reset is held.
`define WSD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that is checked on every clock edge, reset included.
`define WSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/wsd_pkg.sv
// ---------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame header parser and output stage.
// ---------------------------------------------------------------------------
package wsd_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned OpcodeW = 4;
    localparam int unsigned LenW    = 64;
    localparam int unsigned ExtCntW = 4;
    localparam int unsigned MaskCntW = 3;

    localparam logic [6:0] Len16Code = 7'd126;
    localparam logic [6:0] Len64Code = 7'd127;
    localparam logic [ExtCntW-1:0]  Ext16Bytes = 4'd2;
    localparam logic [ExtCntW-1:0]  Ext64Bytes = 4'd8;
    localparam logic [MaskCntW-1:0] MaskKeyBytes = 3'd4;

    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    // One result as it leaves the parser.
    typedef struct packed {
        logic [ByteW-1:0]   data;
        logic               last;
        logic               empty;
        logic [OpcodeW-1:0] opcode;
        logic               fin;
    } result_t;

endpackage

### hdl/wsd_parser.sv
// ---------------------------------------------------------------------------
// WebSocket frame header parser
// Walks the header, extended length, mask key and payload of each frame, one byte
// per accepted transaction, and produces at most one result per byte.
// ---------------------------------------------------------------------------
module wsd_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  logic [wsd_pkg::ByteW-1:0]  in_byte,
    output logic                       res_valid,
    output wsd_pkg::result_t           res
);
    import wsd_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [ExtCntW-1:0]    ext_left_reg, ext_left_next;
    logic [MaskCntW-1:0]   mask_left_reg, mask_left_next;
    logic [LenW-1:0]       remain_reg, remain_next;
    logic [OpcodeW-1:0]    opcode_reg, opcode_next;
    logic                  fin_reg, fin_next;
    logic                  masked_reg, masked_next;

    logic [6:0]            len7;
    logic [LenW-1:0]       remain_shift;
    logic [ExtCntW-1:0]    ext_dec;
    logic [MaskCntW-1:0]   mask_dec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR1;
            ext_left_reg  <= '0;
            mask_left_reg <= '0;
            remain_reg    <= '0;
            opcode_reg    <= '0;
            fin_reg       <= 1'b0;
            masked_reg    <= 1'b0;
        end else if (in_valid) begin
            phase_reg     <= phase_next;
            ext_left_reg  <= ext_left_next;
            mask_left_reg <= mask_left_next;
            remain_reg    <= remain_next;
            opcode_reg    <= opcode_next;
            fin_reg       <= fin_next;
            masked_reg    <= masked_next;
        end
    end

    assign len7         = in_byte[6:0];
    assign remain_shift = {remain_reg[LenW-ByteW-1:0], in_byte};
    assign ext_dec      = (ext_left_reg != '0) ? ext_left_reg - 1'b1 : ext_left_reg;
    assign mask_dec     = (mask_left_reg != '0) ? mask_left_reg - 1'b1 : mask_left_reg;

    always_comb begin
        phase_next     = phase_reg;
        ext_left_next  = ext_left_reg;
        mask_left_next = mask_left_reg;
        remain_next    = remain_reg;
        opcode_next    = opcode_reg;
        fin_next       = fin_reg;
        masked_next    = masked_reg;
        res_valid      = 1'b0;
        res.data       = '0;
        res.last       = 1'b1;
        res.empty      = 1'b1;
        res.opcode     = opcode_reg;
        res.fin        = fin_reg;

        unique case (phase_reg)
            PH_HDR2: begin
                masked_next = in_byte[7];
                if (len7 == Len16Code) begin
                    remain_next   = '0;
                    ext_left_next = Ext16Bytes;
                    phase_next    = PH_EXTLEN;
                end else if (len7 == Len64Code) begin
                    remain_next   = '0;
                    ext_left_next = Ext64Bytes;
                    phase_next    = PH_EXTLEN;
                end else begin
                    remain_next = {{(LenW-7){1'b0}}, len7};
                    if (in_byte[7]) begin
                        mask_left_next = MaskKeyBytes;
                        phase_next     = PH_MASK;
                    end else if (len7 == '0) begin
                        res_valid  = 1'b1;
                        phase_next = PH_HDR1;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_EXTLEN: begin
                remain_next   = remain_shift;
                ext_left_next = ext_dec;
                if (ext_dec == '0) begin
                    if (masked_reg) begin
                        mask_left_next = MaskKeyBytes;
                        phase_next     = PH_MASK;
                    end else if (remain_shift == '0) begin
                        res_valid  = 1'b1;
                        phase_next = PH_HDR1;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_MASK: begin
                mask_left_next = mask_dec;
                if (mask_dec == '0) begin
                    if (remain_reg == '0) begin
                        res_valid  = 1'b1;
                        phase_next = PH_HDR1;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                remain_next = remain_reg - 1'b1;
                res_valid   = 1'b1;
                res.data    = in_byte;
                res.empty   = 1'b0;
                res.last    = (remain_reg == {{(LenW-1){1'b0}}, 1'b1});
                if (res.last) begin
                    phase_next = PH_HDR1;
                end
            end
            default: begin
                // First header byte; unused phase codes land here as well.
                fin_next       = in_byte[7];
                opcode_next    = in_byte[OpcodeW-1:0];
                masked_next    = 1'b0;
                ext_left_next  = '0;
                mask_left_next = '0;
                remain_next    = '0;
                phase_next     = PH_HDR2;
            end
        endcase
    end

endmodule

### hdl/wsd_out_reg.sv
// ---------------------------------------------------------------------------
// WebSocket deframer output register
// Holds one result until the downstream side takes it; refills in the same
// cycle that the held result leaves.
// ---------------------------------------------------------------------------
module wsd_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic              res_valid,
    input  wsd_pkg::result_t  res,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output wsd_pkg::result_t  out_res
);
    import wsd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign can_load = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = res_valid;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res_valid) begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

### hdl/websocket_frame_deframer.sv
// ---------------------------------------------------------------------------
// WebSocket frame deframer
// Strips WebSocket frame headers from a byte stream and forwards payload
// bytes tagged with opcode, fin bit, end of frame and empty frame marks.
// ---------------------------------------------------------------------------
//  Channel | Direction | tdata          | tlast          | tuser
//  s_      | in        | rx_byte        | -              | -
//  m_      | out       | out_byte       | last_of_frame  | empty_frame, frame_opcode,
//          |           |                |                | final_fragment
//
//  One byte is taken every cycle while s_tready is high; a result appears in the
//  cycle after the byte that causes it, from a single output register.
//  Header, length and mask key bytes give no result; an empty frame gives
//  one result on the byte that completes its header.
//  s_tready drops only while a held result is not taken by m_tready.
//  aresetn is synchronous; after reset the parser waits for a first header byte.
// ---------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [5:0]  m_tuser    // [0] empty_frame, [4:1] frame_opcode, [5] final_fragment
);
    import wsd_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_res;
    logic    can_load;

    assign s_tready = can_load;
    assign accept   = s_tvalid && can_load;

    wsd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .res_valid (res_valid),
        .res       (res),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.data;
    assign m_tlast = out_res.last;
    assign m_tuser = {out_res.fin, out_res.opcode, out_res.empty};

endmodule

### hdl/wsd_checker.sv
// ---------------------------------------------------------------------------
// WebSocket deframer port checker
// Watches the top-level ports for output stalls, frame tagging and
// back-pressure behaviour.
// ---------------------------------------------------------------------------
`include "websocket_frame_deframer_macros.svh"

module wsd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic [5:0]  m_tuser
);

    `WSD_ASSERT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output changed while stalled")

    `WSD_ASSERT(a_empty_marks, aclk, aresetn, m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 8'd0), "empty frame result not marked last with zero data")

    // Within a frame, consecutive results carry the same opcode and fin bit.
    `WSD_ASSERT(a_frame_tags, aclk, aresetn, m_tvalid && m_tready && !m_tlast |=> !m_tvalid || (!m_tuser[0] && (m_tuser[5:1] == $past(m_tuser[5:1]))), "frame tags changed inside a frame")

    `WSD_ASSERT(a_ready_only_on_stall, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready, "input stalled without output back-pressure")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
